// File: hdl/key_matrix_hid_report_builder_unit_assert.svh
// Assertion macros shared by the report builder modules.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef KEY_MATRIX_HID_REPORT_BUILDER_UNIT_ASSERT_SVH
`define KEY_MATRIX_HID_REPORT_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KMHID_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kmhid assertion failed");

// Next-cycle implication.
`define KMHID_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kmhid assertion failed");

`endif

// File: hdl/kmhid_pkg.sv
`default_nettype none
package kmhid_pkg;

    // Block sizes
    localparam int NUM_COLUMNS   = 14;
    localparam int NUM_KEY_SLOTS = 6;
    localparam int MASK_ROWS     = 16;

    // Fixed field widths of the transactions
    localparam int COLUMN_W   = 4;
    localparam int ROW_MASK_W = 16;
    localparam int CODE_W     = 8;
    localparam int OUT_SLOTS  = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = CODE_W * (OUT_SLOTS + 1);

    // Derived index widths
    localparam int COL_IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROW_W     = $clog2(MASK_ROWS);
    localparam int SLOT_W    = (NUM_KEY_SLOTS > 1) ? $clog2(NUM_KEY_SLOTS) : 1;

    // Usage code ranges
    localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [CODE_W-1:0] MOD_END   = 8'hE8;
    localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;

    typedef logic [CODE_W-1:0] t_code;

    // Request from the row sequencer to the key list
    typedef struct packed {
        logic  start;
        logic  remove;
        t_code code;
    } t_list_req;

    // Usage ROM covering rows 1..9 and columns 0..13
    localparam int ROM_ROWS  = 9;
    localparam int ROM_COLS  = 14;
    localparam int ROM_ROW_W = $clog2(ROM_ROWS);
    localparam int ROM_COL_W = $clog2(ROM_COLS);

    localparam t_code USAGE_ROM [ROM_ROWS][ROM_COLS] = '{
        '{8'h3a, 8'h29, 8'h1f, 8'h1e, 8'h35, 8'h14, 8'h2b,
          8'h04, 8'h39, 8'h64, 8'h1d, 8'he1, 8'he3, 8'he0},
        '{8'h3c, 8'h3b, 8'h20, 8'h21, 8'h08, 8'h1a, 8'h15,
          8'h16, 8'h09, 8'h07, 8'h1b, 8'h06, 8'h8b, 8'he2},
        '{8'h3e, 8'h3d, 8'h24, 8'h22, 8'h23, 8'h1c, 8'h17,
          8'h0b, 8'h0a, 8'h05, 8'h11, 8'h19, 8'h2c, 8'h88},
        '{8'h3f, 8'h40, 8'h25, 8'h26, 8'h0c, 8'h18, 8'h12,
          8'h0d, 8'h0f, 8'h0e, 8'h10, 8'h37, 8'h36, 8'h8a},
        '{8'h42, 8'h41, 8'h2e, 8'h27, 8'h2d, 8'h2f, 8'h13,
          8'h30, 8'h33, 8'h34, 8'h32, 8'h38, 8'he7, 8'he6},
        '{8'h43, 8'h45, 8'h89, 8'h44, 8'h2a, 8'h49, 8'h4c,
          8'h4d, 8'h31, 8'h28, 8'he5, 8'h87, 8'h65, 8'he4},
        '{8'h48, 8'h46, 8'h53, 8'h47, 8'h4b, 8'h4a, 8'h5f,
          8'h4e, 8'h5c, 8'h59, 8'h52, 8'h51, 8'h4f, 8'h50},
        '{8'h00, 8'h00, 8'hf1, 8'hf0, 8'h54, 8'h61, 8'h60,
          8'h5e, 8'h5d, 8'h5a, 8'h5b, 8'h62, 8'h85, 8'h63},
        '{8'hf3, 8'h00, 8'hf2, 8'h00, 8'h55, 8'h56, 8'h57,
          8'h86, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h58}
    };

    // Look up a key; row zero and keys outside the ROM give usage zero
    function automatic t_code usage_lookup(input logic [ROW_W-1:0] row,
                                           input logic [COL_IDX_W-1:0] col);
        logic [ROW_W-1:0]     row_m1;
        logic [ROM_ROW_W-1:0] r_i;
        logic [ROM_COL_W-1:0] c_i;
        row_m1 = row - ROW_W'(1);
        r_i    = ROM_ROW_W'(row_m1);
        c_i    = ROM_COL_W'(col);
        if (row == '0 || int'(row) > ROM_ROWS || int'(col) >= ROM_COLS) begin
            return '0;
        end
        return USAGE_ROM[r_i][c_i];
    endfunction

endpackage
`default_nettype wire

// File: hdl/kmhid_key_list.sv
`default_nettype none
`include "key_matrix_hid_report_builder_unit_assert.svh"
module kmhid_key_list (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kmhid_pkg::t_list_req i_req,
    output logic                    o_done,
    output kmhid_pkg::t_code        o_slots [kmhid_pkg::NUM_KEY_SLOTS],
    output logic                    o_overflow
);
    import kmhid_pkg::*;

    typedef enum logic [0:0] {
        L_IDLE,
        L_FIND
    } t_lstate;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_KEY_SLOTS - 1);

    t_lstate           r_state, n_state;
    t_code             r_list [NUM_KEY_SLOTS];
    t_code             n_list [NUM_KEY_SLOTS];
    t_code             r_code, n_code;
    logic              r_remove, n_remove;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_done, n_done;
    logic              r_overflow, n_overflow;

    t_code entry;
    logic  hit;
    logic  empty;
    logic  last;

    // Shared compare unit on the visited slot
    assign entry = r_list[r_idx];
    assign hit   = (entry == r_code);
    assign empty = (entry == '0);
    assign last  = (r_idx == LAST_SLOT);

    // Walk the slots one per cycle for an add or a remove
    always_comb begin
        n_state    = r_state;
        n_list     = r_list;
        n_code     = r_code;
        n_remove   = r_remove;
        n_idx      = r_idx;
        n_done     = 1'b0;
        n_overflow = r_overflow;
        unique case (r_state)
            L_IDLE: begin
                if (i_req.start) begin
                    n_code   = i_req.code;
                    n_remove = i_req.remove;
                    n_idx    = '0;
                    n_state  = L_FIND;
                end
            end
            L_FIND: begin
                if (!r_remove) begin
                    if (hit) begin
                        n_done = 1'b1;
                    end else if (empty) begin
                        n_list[r_idx] = r_code;
                        n_done        = 1'b1;
                    end else if (last) begin
                        n_overflow = 1'b1;
                        n_done     = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (empty) begin
                        n_done = 1'b1;
                    end else if (hit) begin
                        // Close the gap: shift every later slot down by one
                        for (int k = 0; k < NUM_KEY_SLOTS - 1; k++) begin
                            if (SLOT_W'(k) >= r_idx) begin
                                n_list[k] = r_list[k + 1];
                            end
                        end
                        n_list[NUM_KEY_SLOTS - 1] = '0;
                        n_overflow = 1'b0;
                        n_done     = 1'b1;
                    end else if (last) begin
                        n_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (n_done) begin
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= L_IDLE;
            r_done     <= 1'b0;
            r_overflow <= 1'b0;
            for (int k = 0; k < NUM_KEY_SLOTS; k++) begin
                r_list[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_overflow <= n_overflow;
            r_list     <= n_list;
        end
        r_code   <= n_code;
        r_remove <= n_remove;
        r_idx    <= n_idx;
    end

    assign o_done     = r_done;
    assign o_slots    = r_list;
    assign o_overflow = r_overflow;

    // Overflow only ever stands over a full list
    `KMHID_CHECK(a_ovf_full, r_overflow, r_list[NUM_KEY_SLOTS - 1] != '0)
    // A new request only arrives when the walk is idle
    `KMHID_CHECK(a_start_idle, i_req.start, r_state == L_IDLE)
    // An add that finds no room raises overflow
    `KMHID_CHECK_NEXT(a_add_fail, r_state == L_FIND && !r_remove && !hit && !empty && last,
        r_overflow)

endmodule
`default_nettype wire

// File: hdl/key_matrix_hid_report_builder_unit.sv
// Sequence: the column is loaded, then the mask rows are walked in order, one row per cycle
//   unless a changed list key (usage below the modifiers) pauses the walk for its slot walk,
//   which runs on the shared compare unit of the key list; after the last column the report
//   is loaded, held off while an earlier report still waits on the output.
// A new column is taken only in idle, once the previous column is fully processed.
// Reset clears the stored column masks, key list, modifiers, overflow and output valid.
`default_nettype none
`include "key_matrix_hid_report_builder_unit_assert.svh"
module key_matrix_hid_report_builder_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: column [3:0], row_mask [19:4], zero [23:20]
    input  wire logic [kmhid_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: modifiers [7:0], key_slot_0 [15:8] .. key_slot_5 [55:48]
    output logic [kmhid_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // tuser: rollover [0]
    output logic                                     o_m_axis_tuser
);
    import kmhid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LIST,
        S_EMIT
    } t_state;

    localparam logic [ROW_W-1:0]     LAST_ROW = ROW_W'(MASK_ROWS - 1);
    localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(NUM_COLUMNS - 1);

    t_state                 r_state, n_state;
    logic [MASK_ROWS-1:0]   r_prev [NUM_COLUMNS];
    logic [MASK_ROWS-1:0]   n_prev [NUM_COLUMNS];
    logic [COL_IDX_W-1:0]   r_col, n_col;
    logic [MASK_ROWS-1:0]   r_new, n_new;
    logic [MASK_ROWS-1:0]   r_changed, n_changed;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [CODE_W-1:0]      r_mods, n_mods;
    t_list_req              r_req, n_req;
    logic                   r_out_valid, n_out_valid;
    logic [CODE_W-1:0]      r_out_mods, n_out_mods;
    t_code                  r_out_slots [OUT_SLOTS];
    t_code                  n_out_slots [OUT_SLOTS];
    logic                   r_out_roll, n_out_roll;

    logic [COLUMN_W-1:0]    in_column;
    logic [MASK_ROWS-1:0]   in_mask;
    logic [COL_IDX_W-1:0]   col_idx;
    t_code                  key_code;
    logic                   is_list;
    logic                   is_mod;
    logic                   advance;
    logic                   list_done;
    logic                   list_ovf;
    t_code                  list_slots [NUM_KEY_SLOTS];
    t_code                  slot_view [OUT_SLOTS];

    // Unpack the input transaction; rows beyond the mask width drop out
    assign in_column = i_s_axis_tdata[COLUMN_W-1:0];
    assign in_mask   = MASK_ROWS'(i_s_axis_tdata[COLUMN_W +: ROW_MASK_W]);
    assign col_idx   = COL_IDX_W'(in_column);

    // Classify the key at the current row
    assign key_code = usage_lookup(r_row, r_col);
    assign is_list  = (key_code != '0) && (key_code < MOD_FIRST);
    assign is_mod   = (key_code >= MOD_FIRST) && (key_code < MOD_END);

    kmhid_key_list u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_req),
        .o_done     (list_done),
        .o_slots    (list_slots),
        .o_overflow (list_ovf)
    );

    // Pad the list out to the report's slot count
    always_comb begin
        for (int j = 0; j < OUT_SLOTS; j++) begin
            slot_view[j] = '0;
        end
        for (int j = 0; j < NUM_KEY_SLOTS && j < OUT_SLOTS; j++) begin
            slot_view[j] = list_slots[j];
        end
    end

    // Row sequencer
    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_col       = r_col;
        n_new       = r_new;
        n_changed   = r_changed;
        n_row       = r_row;
        n_mods      = r_mods;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_mods  = r_out_mods;
        n_out_slots = r_out_slots;
        n_out_roll  = r_out_roll;
        advance     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // Take a column; drop columns past the matrix
                if (i_s_axis_tvalid && int'(in_column) < NUM_COLUMNS) begin
                    n_col           = col_idx;
                    n_new           = in_mask;
                    n_changed       = in_mask ^ r_prev[col_idx];
                    n_prev[col_idx] = in_mask;
                    n_row           = '0;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_changed[r_row] && is_list) begin
                    n_req.start  = 1'b1;
                    n_req.remove = ~r_new[r_row];
                    n_req.code   = key_code;
                    n_state      = S_LIST;
                end else begin
                    if (r_changed[r_row] && is_mod) begin
                        n_mods[key_code[2:0]] = r_new[r_row];
                    end
                    advance = 1'b1;
                end
            end
            S_LIST: begin
                // Resume the row walk once the list is done
                if (list_done) begin
                    advance = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                // Load the report once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_mods  = r_mods;
                    n_out_roll  = list_ovf;
                    for (int j = 0; j < OUT_SLOTS; j++) begin
                        n_out_slots[j] = list_ovf ? ROLLOVER_CODE : slot_view[j];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Step to the next row or finish the column
        if (advance) begin
            if (r_row == LAST_ROW) begin
                n_state = (r_col == LAST_COL) ? S_EMIT : S_IDLE;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mods      <= '0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_prev[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_mods      <= n_mods;
            r_req.start <= n_req.start;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
        end
        r_req.remove <= n_req.remove;
        r_req.code   <= n_req.code;
        r_col        <= n_col;
        r_new        <= n_new;
        r_changed    <= n_changed;
        r_row        <= n_row;
        r_out_mods   <= n_out_mods;
        r_out_slots  <= n_out_slots;
        r_out_roll   <= n_out_roll;
    end

    // Pack the output transaction
    always_comb begin
        o_m_axis_tdata[CODE_W-1:0] = r_out_mods;
        for (int j = 0; j < OUT_SLOTS; j++) begin
            o_m_axis_tdata[CODE_W*(j+1) +: CODE_W] = r_out_slots[j];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_roll;

    // A report is only built after the last column
    `KMHID_CHECK(a_emit_last, r_state == S_EMIT, r_col == LAST_COL)
    // A rollover report carries the error code in its slots
    `KMHID_CHECK(a_roll_slots, r_out_valid && r_out_roll,
        r_out_slots[0] == ROLLOVER_CODE && r_out_slots[OUT_SLOTS - 1] == ROLLOVER_CODE)
    // A list request is always followed by waiting for the list
    `KMHID_CHECK(a_req_wait, r_req.start, r_state == S_LIST)

endmodule
`default_nettype wire

// File: test/kmhid_report_checker.sv
// Watches both stream channels of the report builder, predicts the boot report
// that each transaction of the last column produces, and compares every report that leaves the block.
module kmhid_report_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_tvalid,
    input  wire logic                              i_in_tready,
    // tdata: column [3:0], row_mask [19:4], zero [23:20]
    input  wire logic [kmhid_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  wire logic                              i_out_tvalid,
    input  wire logic                              i_out_tready,
    // tdata: modifiers [7:0], key_slot_0 [15:8] .. key_slot_5 [55:48]
    input  wire logic [kmhid_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    // tuser: rollover [0]
    input  wire logic                              i_out_tuser,
    output int                                     o_fail_count,
    output int                                     o_reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kmhid_pkg::*;

    typedef struct packed {
        logic                  rollover;
        t_code [OUT_SLOTS-1:0] slots;
        t_code                 modifiers;
    } t_hid_report;

    // Shadow of the keyboard state held by the block
    logic [MASK_ROWS-1:0] column_masks [NUM_COLUMNS];
    t_code                key_list [NUM_KEY_SLOTS];
    t_code                modifier_bits;
    logic                 rollover_flag;

    t_hid_report expected_reports [$];
    int          mismatch_count = 0;

    initial begin
        o_fail_count      = 0;
        o_reports_pending = 0;
    end

    task automatic log_mismatch(input string what);
        $display("[%0t] report mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        int                   col;
        int                   hit;
        logic [MASK_ROWS-1:0] mask;
        logic [MASK_ROWS-1:0] changed;
        t_code                code;
        logic                 down;
        logic                 placed;
        t_hid_report          got;
        t_hid_report          want;

        if (!i_rst_n) begin
            foreach (column_masks[c]) column_masks[c] = '0;
            foreach (key_list[i]) key_list[i] = '0;
            modifier_bits = '0;
            rollover_flag = 1'b0;
            expected_reports.delete();
        end else begin
            // Compare a report transaction with the oldest prediction
            if (i_out_tvalid && i_out_tready) begin
                got = t_hid_report'({i_out_tuser, i_out_tdata});
                if (expected_reports.size() == 0) begin
                    log_mismatch($sformatf("report %h arrived with none expected", got));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.modifiers !== want.modifiers)
                        log_mismatch($sformatf("modifiers got %h expected %h",
                                               got.modifiers, want.modifiers));
                    for (int j = 0; j < OUT_SLOTS; j++) begin
                        if (got.slots[j] !== want.slots[j])
                            log_mismatch($sformatf("key_slot_%0d got %h expected %h",
                                                   j, got.slots[j], want.slots[j]));
                    end
                    if (got.rollover !== want.rollover)
                        log_mismatch($sformatf("rollover got %b expected %b",
                                               got.rollover, want.rollover));
                end
            end

            // Apply a column transaction to the shadow state
            if (i_in_tvalid && i_in_tready) begin
                col  = int'(i_in_tdata[COLUMN_W-1:0]);
                mask = i_in_tdata[COLUMN_W +: ROW_MASK_W];
                if (col < NUM_COLUMNS) begin
                    changed = mask ^ column_masks[col];
                    column_masks[col] = mask;
                    // Walk changed rows in ascending order
                    for (int r = 0; r < MASK_ROWS; r++) begin
                        if (!changed[r] || r == 0 || r > ROM_ROWS || col >= ROM_COLS)
                            continue;
                        code = USAGE_ROM[r-1][col];
                        down = mask[r];
                        if (code == '0 || code >= MOD_END)
                            continue;
                        if (code >= MOD_FIRST) begin
                            modifier_bits[code[2:0]] = down;
                            continue;
                        end
                        if (down) begin
                            // Add without duplicates; a full list raises rollover
                            placed = 1'b0;
                            for (int i = 0; i < NUM_KEY_SLOTS && !placed; i++) begin
                                if (key_list[i] == code) begin
                                    placed = 1'b1;
                                end else if (key_list[i] == '0) begin
                                    key_list[i] = code;
                                    placed = 1'b1;
                                end
                            end
                            if (!placed)
                                rollover_flag = 1'b1;
                        end else begin
                            // Remove with compaction; a found key clears rollover
                            hit = -1;
                            for (int i = 0; i < NUM_KEY_SLOTS && hit < 0 && key_list[i] != '0;
                                 i++) begin
                                if (key_list[i] == code)
                                    hit = i;
                            end
                            if (hit >= 0) begin
                                for (int j = hit; j < NUM_KEY_SLOTS - 1; j++)
                                    key_list[j] = key_list[j+1];
                                key_list[NUM_KEY_SLOTS-1] = '0;
                                rollover_flag = 1'b0;
                            end
                        end
                    end

                    // The last column of a scan produces the boot report
                    if (col == NUM_COLUMNS - 1) begin
                        want.modifiers = modifier_bits;
                        want.rollover  = rollover_flag;
                        for (int j = 0; j < OUT_SLOTS; j++) begin
                            if (rollover_flag)
                                want.slots[j] = ROLLOVER_CODE;
                            else if (j < NUM_KEY_SLOTS)
                                want.slots[j] = key_list[j];
                            else
                                want.slots[j] = '0;
                        end
                        expected_reports.push_back(want);
                    end
                end
            end
        end

        o_fail_count      <= mismatch_count;
        o_reports_pending <= expected_reports.size();
    end

endmodule

// File: test/tb_key_matrix_hid_report_builder_unit.sv
// Drives scanned matrix columns into the report builder and gives the verdict.
module tb_key_matrix_hid_report_builder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kmhid_pkg::*;

    localparam int ITEM_TARGET    = 1200;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // Directed scans as {row_mask, column}
    localparam logic [19:0] DIRECTED_SCANS [18] = '{
        {16'h0000, 4'd13},   // empty report
        {16'hFFFF, 4'd15},   // columns beyond the matrix are dropped
        {16'hFFFF, 4'd14},
        {16'hFFFF, 4'd13},   // modifiers plus five list keys, ignored rows
        {16'hFFFF, 4'd12},   // list fills, then overflows
        {16'hFFFF, 4'd13},   // rollover report
        {16'hFFF7, 4'd12},   // release of a key that never made the list
        {16'hFFFF, 4'd13},   // rollover still held
        {16'h0000, 4'd12},   // release of a listed key clears rollover
        {16'hFFFF, 4'd13},
        {16'hFFFF, 4'd0},    // zero usage and codes above the modifiers
        {16'h0402, 4'd11},   // modifier press, row ten ignored
        {16'h0001, 4'd13},   // row zero ignored, column releases
        {16'h0000, 4'd0},
        {16'h0000, 4'd11},
        {16'h0000, 4'd13},
        {16'h8001, 4'd5},    // only ignored rows change
        {16'h0000, 4'd13}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int fail_count;
    int reports_pending;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit ready_free = 1'b0;
    bit no_gaps = 1'b0;

    // Keys currently held down, per column, as last sent
    logic [MASK_ROWS-1:0] key_state [NUM_COLUMNS] = '{default: '0};

    always #2 clk = ~clk;

    key_matrix_hid_report_builder_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    kmhid_report_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_tvalid       (s_tvalid),
        .i_in_tready       (s_tready),
        .i_in_tdata        (s_tdata),
        .i_out_tvalid      (m_tvalid),
        .i_out_tready      (m_tready),
        .i_out_tdata       (m_tdata),
        .i_out_tuser       (m_tuser),
        .o_fail_count      (fail_count),
        .o_reports_pending (reports_pending)
    );

    // Send one column transaction after a random gap; valid stays high between
    // back-to-back transactions
    task automatic send_column(input logic [COLUMN_W-1:0] col,
                               input logic [MASK_ROWS-1:0] mask);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (col < NUM_COLUMNS)
            key_state[col] = mask;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - COLUMN_W - ROW_MASK_W){1'b0}}, mask, col};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Stall the report side: mostly short, a few long, with free-running stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 499) == 0)
            ready_free = !ready_free;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!ready_free && $urandom_range(0, 99) < 30) begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 80);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                   target;
        int                   pressed;
        int                   col;
        int                   row;
        int                   skip_col;
        int                   burst;
        bit                   want_press;
        logic [MASK_ROWS-1:0] mask;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corner scans
        foreach (DIRECTED_SCANS[i])
            send_column(DIRECTED_SCANS[i][3:0], DIRECTED_SCANS[i][19:4]);

        while (items_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 12) begin
                // Noise: stray columns with arbitrary masks
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    col  = $urandom_range(0, 15);
                    mask = MASK_ROWS'($urandom());
                    if ($urandom_range(0, 1) == 1)
                        mask &= MASK_ROWS'($urandom());
                    send_column(COLUMN_W'(col), mask);
                end
            end else begin
                // Full scan: press or release a few keys, steering the held
                // count around the list size so overflow comes and goes
                target = $urandom_range(0, 10);
                repeat ($urandom_range(0, 4)) begin
                    pressed = 0;
                    for (int c = 0; c < NUM_COLUMNS; c++)
                        pressed += $countones(key_state[c][ROM_ROWS:1]);
                    want_press = (pressed < target);
                    for (int tries = 0; tries < 64; tries++) begin
                        col = $urandom_range(0, NUM_COLUMNS - 1);
                        row = $urandom_range(1, ROM_ROWS);
                        if (key_state[col][row] != want_press) begin
                            key_state[col][row] = want_press;
                            break;
                        end
                    end
                end
                // Toggle a row outside the usage table now and then
                if ($urandom_range(0, 7) == 0) begin
                    col = $urandom_range(0, NUM_COLUMNS - 1);
                    row = $urandom_range(0, MASK_ROWS - ROM_ROWS - 1);
                    row = (row == 0) ? 0 : row + ROM_ROWS;
                    key_state[col][row] = ~key_state[col][row];
                end
                // Occasionally drop one column from the scan
                skip_col = ($urandom_range(0, 19) == 0) ? $urandom_range(0, NUM_COLUMNS - 1)
                                                        : NUM_COLUMNS;
                for (int c = 0; c < NUM_COLUMNS; c++) begin
                    if (c != skip_col)
                        send_column(COLUMN_W'(c), key_state[c]);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding reports, then watch for strays
        while (reports_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && reports_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
